// ===== rtl/core/sector_buffer_cache_lru_top_assert.svh =====
// Assertion macros for the sector buffer cache.
// Included by the RTL files that carry concurrent assertions; no other dependencies.
`ifndef SECTOR_BUFFER_CACHE_LRU_TOP_ASSERT_SVH
`define SECTOR_BUFFER_CACHE_LRU_TOP_ASSERT_SVH
`ifndef SYNTH
// The consequent must hold in the same cycle as the antecedent.
`define SBC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sbc: same-cycle check failed");
// The consequent must hold in the cycle after the antecedent.
`define SBC_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sbc: next-cycle check failed");
`else
`define SBC_ASSERT_IMP(label, clk, rst, ante, cons)
`define SBC_ASSERT_NXT(label, clk, rst, ante, cons)
`endif
`endif

// ===== rtl/core/sbc_pkg.sv =====
// Shared constants, codes and controller/datapath structs of the sector buffer cache.
// No dependencies; every RTL module and interface imports it.
package sbc_pkg;

   localparam int NUM_BUFFERS = 16;
   localparam int AGE_BITS    = 16;
   localparam int IDX_W       = (NUM_BUFFERS > 1) ? $clog2(NUM_BUFFERS) : 1;
   localparam int SECTOR_W    = 32;
   localparam int BUF_W       = 4;
   localparam logic [AGE_BITS-1:0] AGE_MAX = '1;

   typedef enum logic [1:0] {
      OP_LOAD,
      OP_ALLOC,
      OP_MARK,
      OP_FLUSH
   } op_type;

   typedef enum logic [2:0] {
      KIND_WRITEBACK,
      KIND_FETCH,
      KIND_ZERO,
      KIND_DONE,
      KIND_ERROR
   } kind_type;

   typedef enum logic [1:0] {
      ST_FREE,
      ST_CLEAN,
      ST_DIRTY
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_SCAN,
      S_DECIDE,
      S_FILL,
      S_DONE,
      S_ERROR,
      S_MARK,
      S_FLUSH,
      S_FLUSH_END
   } state_type;

   typedef enum logic [1:0] {
      BUF_SLOT,
      BUF_INDEX,
      BUF_REQ,
      BUF_ZERO
   } buf_sel_type;

   typedef enum logic [1:0] {
      SEC_REQ,
      SEC_TAG,
      SEC_VICTIM,
      SEC_ZERO
   } sec_sel_type;

   typedef enum logic {
      WR_SLOT,
      WR_INDEX
   } wr_at_type;

   typedef struct packed {
      logic        take;
      logic        scan_step;
      logic        idx_inc;
      logic        emit;
      kind_type    kind;
      buf_sel_type buf_sel;
      sec_sel_type sec_sel;
      logic        last;
      logic        st_write;
      wr_at_type   st_at;
      status_type  st_value;
      logic        tag_write;
      logic        touch;
      logic        fail_set;
   } cmd_type;

   typedef struct packed {
      logic       req_valid;
      op_type     op;
      logic       read_fails;
      logic       write_fails;
      logic       hit;
      logic       victim_dirty;
      logic       idx_last;
      status_type cur_status;
      logic       bidx_oob;
      logic       failed;
      logic       out_free;
   } sts_type;

endpackage

// ===== rtl/core/sbc_channel_if.sv =====
// Request and result channel interfaces of the sector buffer cache.
// Depends on sbc_pkg for field widths and codes.
interface sbc_req_if import sbc_pkg::*; ();
   logic                valid;
   logic                ready;
   op_type              op;
   logic [SECTOR_W-1:0] sector;
   logic [BUF_W-1:0]    buffer_index;
   logic                read_fails;
   logic                write_fails;

   modport source (output valid, op, sector, buffer_index, read_fails, write_fails,
                   input ready);
   modport sink (input valid, op, sector, buffer_index, read_fails, write_fails,
                 output ready);
endinterface

interface sbc_rsp_if import sbc_pkg::*; ();
   logic                valid;
   logic                ready;
   kind_type            kind;
   logic [BUF_W-1:0]    buffer;
   logic [SECTOR_W-1:0] sector_out;
   logic                last;

   modport source (output valid, kind, buffer, sector_out, last, input ready);
   modport sink (input valid, kind, buffer, sector_out, last, output ready);
endinterface

// ===== rtl/core/sbc_datapath.sv =====
// Datapath of the sector buffer cache: request capture, buffer status/tag/age
// registers, scan accumulators and the result register. Depends on sbc_pkg
// and the channel interfaces.
module sbc_datapath import sbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sbc_req_if.sink   req,
   sbc_rsp_if.source rsp,
   input  cmd_type   cmd,
   output sts_type   sts
);

   // Captured request.
   op_type              op_ff;
   logic [SECTOR_W-1:0] sector_ff;
   logic [BUF_W-1:0]    bidx_ff;
   logic                rf_ff;
   logic                wf_ff;

   // Buffer state.
   status_type          status_ff [NUM_BUFFERS];
   status_type          status_in [NUM_BUFFERS];
   logic [SECTOR_W-1:0] tag_ff    [NUM_BUFFERS];
   logic [AGE_BITS-1:0] age_ff    [NUM_BUFFERS];
   logic [AGE_BITS-1:0] age_in    [NUM_BUFFERS];

   // Scan pointer and accumulators.
   logic [IDX_W-1:0]    idx_ff, idx_in;
   logic                hit_ff, hit_in;
   logic [IDX_W-1:0]    hit_idx_ff, hit_idx_in;
   logic                free_ff, free_in;
   logic [IDX_W-1:0]    free_idx_ff, free_idx_in;
   logic [IDX_W-1:0]    best_idx_ff, best_idx_in;
   logic [AGE_BITS-1:0] best_age_ff, best_age_in;
   logic [SECTOR_W-1:0] best_tag_ff, best_tag_in;
   logic                best_dirty_ff, best_dirty_in;
   logic                failed_ff, failed_in;

   // Result register.
   logic                rsp_valid_ff, rsp_valid_in;
   kind_type            kind_ff, kind_in;
   logic [BUF_W-1:0]    buf_ff, buf_in;
   logic [SECTOR_W-1:0] sec_ff, sec_in;
   logic                last_ff, last_in;

   logic                accept;
   logic                out_free;
   status_type          cur_status;
   logic [SECTOR_W-1:0] cur_tag;
   logic [AGE_BITS-1:0] cur_age;
   logic [IDX_W-1:0]    slot;
   logic [IDX_W-1:0]    wr_idx;

   assign req.ready  = cmd.take;
   assign accept     = req.valid && req.ready;
   assign out_free   = !rsp_valid_ff || rsp.ready;

   assign cur_status = status_ff[idx_ff];
   assign cur_tag    = tag_ff[idx_ff];
   assign cur_age    = age_ff[idx_ff];

   // A hit wins; otherwise the first free buffer, else the oldest one.
   assign slot   = hit_ff ? hit_idx_ff : (free_ff ? free_idx_ff : best_idx_ff);
   assign wr_idx = (cmd.st_at == WR_SLOT) ? slot : idx_ff;

   always_comb begin
      sts              = '0;
      sts.req_valid    = req.valid;
      sts.op           = op_ff;
      sts.read_fails   = rf_ff;
      sts.write_fails  = wf_ff;
      sts.hit          = hit_ff;
      sts.victim_dirty = !hit_ff && !free_ff && best_dirty_ff;
      sts.idx_last     = (idx_ff == IDX_W'(NUM_BUFFERS - 1));
      sts.cur_status   = cur_status;
      sts.bidx_oob     = (int'(bidx_ff) >= NUM_BUFFERS);
      sts.failed       = failed_ff;
      sts.out_free     = out_free;
   end

   always_comb begin
      idx_in        = idx_ff;
      hit_in        = hit_ff;
      hit_idx_in    = hit_idx_ff;
      free_in       = free_ff;
      free_idx_in   = free_idx_ff;
      best_idx_in   = best_idx_ff;
      best_age_in   = best_age_ff;
      best_tag_in   = best_tag_ff;
      best_dirty_in = best_dirty_ff;
      failed_in     = failed_ff;

      if (accept) begin
         idx_in    = (req.op == OP_MARK) ? IDX_W'(req.buffer_index) : '0;
         hit_in    = 1'b0;
         free_in   = 1'b0;
         failed_in = 1'b0;
      end else begin
         if (cmd.scan_step) begin
            if (!hit_ff && cur_status != ST_FREE && cur_tag == sector_ff) begin
               hit_in     = 1'b1;
               hit_idx_in = idx_ff;
            end
            if (!free_ff && cur_status == ST_FREE) begin
               free_in     = 1'b1;
               free_idx_in = idx_ff;
            end
            // Strictly older replaces, so the lowest index wins a tie.
            if (idx_ff == '0 || cur_age > best_age_ff) begin
               best_idx_in   = idx_ff;
               best_age_in   = cur_age;
               best_tag_in   = cur_tag;
               best_dirty_in = (cur_status == ST_DIRTY);
            end
         end
         if (cmd.idx_inc) begin
            idx_in = idx_ff + IDX_W'(1);
         end
         if (cmd.fail_set) begin
            failed_in = 1'b1;
         end
      end
   end

   always_comb begin
      for (int i = 0; i < NUM_BUFFERS; i++) begin
         status_in[i] = status_ff[i];
         age_in[i]    = age_ff[i];
         if (cmd.st_write && IDX_W'(i) == wr_idx) begin
            status_in[i] = cmd.st_value;
         end
         // Touch: the chosen buffer becomes youngest, all others age by one, saturating at AGE_MAX.
         if (cmd.touch) begin
            if (IDX_W'(i) == slot) begin
               age_in[i] = '0;
            end else if (age_ff[i] != AGE_MAX) begin
               age_in[i] = age_ff[i] + AGE_BITS'(1);
            end
         end
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      kind_in      = kind_ff;
      buf_in       = buf_ff;
      sec_in       = sec_ff;
      last_in      = last_ff;
      if (cmd.emit) begin
         rsp_valid_in = 1'b1;
         kind_in      = cmd.kind;
         last_in      = cmd.last;
         case (cmd.buf_sel)
            BUF_SLOT:  buf_in = BUF_W'(slot);
            BUF_INDEX: buf_in = BUF_W'(idx_ff);
            BUF_REQ:   buf_in = bidx_ff;
            BUF_ZERO:  buf_in = '0;
            default:   buf_in = '0;
         endcase
         case (cmd.sec_sel)
            SEC_REQ:    sec_in = sector_ff;
            SEC_TAG:    sec_in = cur_tag;
            SEC_VICTIM: sec_in = best_tag_ff;
            SEC_ZERO:   sec_in = '0;
            default:    sec_in = '0;
         endcase
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         hit_ff       <= 1'b0;
         free_ff      <= 1'b0;
         failed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            status_ff[i] <= ST_FREE;
            age_ff[i]    <= '0;
         end
      end else begin
         idx_ff       <= idx_in;
         hit_ff       <= hit_in;
         free_ff      <= free_in;
         failed_ff    <= failed_in;
         rsp_valid_ff <= rsp_valid_in;
         for (int i = 0; i < NUM_BUFFERS; i++) begin
            status_ff[i] <= status_in[i];
            age_ff[i]    <= age_in[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff     <= req.op;
         sector_ff <= req.sector;
         bidx_ff   <= req.buffer_index;
         rf_ff     <= req.read_fails;
         wf_ff     <= req.write_fails;
      end
      if (cmd.tag_write) begin
         tag_ff[slot] <= sector_ff;
      end
      hit_idx_ff    <= hit_idx_in;
      free_idx_ff   <= free_idx_in;
      best_idx_ff   <= best_idx_in;
      best_age_ff   <= best_age_in;
      best_tag_ff   <= best_tag_in;
      best_dirty_ff <= best_dirty_in;
      kind_ff       <= kind_in;
      buf_ff        <= buf_in;
      sec_ff        <= sec_in;
      last_ff       <= last_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.kind       = kind_ff;
   assign rsp.buffer     = buf_ff;
   assign rsp.sector_out = sec_ff;
   assign rsp.last       = last_ff;

endmodule

// ===== rtl/core/sbc_ctrl.sv =====
// Controller state machine of the sector buffer cache.
// Depends on sbc_pkg and the assertion macro header.
`include "sector_buffer_cache_lru_top_assert.svh"

module sbc_ctrl import sbc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  sts_type sts,
   output cmd_type cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.take = (state_ff == S_IDLE);
      case (state_ff)
         S_IDLE: begin
            if (sts.req_valid) begin
               state_in = S_SCAN;
            end
         end
         S_SCAN: begin
            // The captured op is only visible from here on.
            if (sts.op == OP_MARK) begin
               state_in = S_MARK;
            end else if (sts.op == OP_FLUSH) begin
               state_in = S_FLUSH;
            end else begin
               cmd.scan_step = 1'b1;
               cmd.idx_inc   = 1'b1;
               if (sts.idx_last) begin
                  state_in = S_DECIDE;
               end
            end
         end
         S_DECIDE: begin
            if (sts.hit && sts.op == OP_LOAD) begin
               if (sts.out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.kind    = KIND_DONE;
                  cmd.buf_sel = BUF_SLOT;
                  cmd.sec_sel = SEC_REQ;
                  cmd.last    = 1'b1;
                  cmd.touch   = 1'b1;
                  state_in    = S_IDLE;
               end
            end else if (sts.victim_dirty) begin
               if (sts.out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.kind    = KIND_WRITEBACK;
                  cmd.buf_sel = BUF_SLOT;
                  cmd.sec_sel = SEC_VICTIM;
                  if (sts.write_fails) begin
                     state_in = S_ERROR;
                  end else begin
                     cmd.st_write = 1'b1;
                     cmd.st_at    = WR_SLOT;
                     cmd.st_value = ST_CLEAN;
                     state_in     = S_FILL;
                  end
               end
            end else begin
               state_in = S_FILL;
            end
         end
         S_FILL: begin
            if (sts.out_free) begin
               cmd.emit     = 1'b1;
               cmd.buf_sel  = BUF_SLOT;
               cmd.sec_sel  = SEC_REQ;
               cmd.st_write = 1'b1;
               cmd.st_at    = WR_SLOT;
               if (sts.op == OP_LOAD) begin
                  cmd.kind = KIND_FETCH;
                  if (sts.read_fails) begin
                     cmd.st_value = ST_FREE;
                     state_in     = S_ERROR;
                  end else begin
                     cmd.st_value  = ST_CLEAN;
                     cmd.tag_write = 1'b1;
                     cmd.touch     = 1'b1;
                     state_in      = S_DONE;
                  end
               end else begin
                  cmd.kind      = KIND_ZERO;
                  cmd.st_value  = ST_DIRTY;
                  cmd.tag_write = 1'b1;
                  cmd.touch     = 1'b1;
                  state_in      = S_DONE;
               end
            end
         end
         S_DONE: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_DONE;
               cmd.buf_sel = BUF_SLOT;
               cmd.sec_sel = SEC_REQ;
               cmd.last    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_ERROR: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = KIND_ERROR;
               cmd.buf_sel = BUF_SLOT;
               cmd.sec_sel = SEC_ZERO;
               cmd.last    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         S_MARK: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.buf_sel = BUF_REQ;
               cmd.last    = 1'b1;
               if (sts.bidx_oob || sts.cur_status == ST_FREE) begin
                  cmd.kind    = KIND_ERROR;
                  cmd.sec_sel = SEC_ZERO;
               end else begin
                  cmd.kind     = KIND_DONE;
                  cmd.sec_sel  = SEC_TAG;
                  cmd.st_write = 1'b1;
                  cmd.st_at    = WR_INDEX;
                  cmd.st_value = ST_DIRTY;
               end
               state_in = S_IDLE;
            end
         end
         S_FLUSH: begin
            if (sts.cur_status == ST_DIRTY) begin
               if (sts.out_free) begin
                  cmd.emit    = 1'b1;
                  cmd.kind    = KIND_WRITEBACK;
                  cmd.buf_sel = BUF_INDEX;
                  cmd.sec_sel = SEC_TAG;
                  if (sts.write_fails) begin
                     cmd.fail_set = 1'b1;
                  end else begin
                     cmd.st_write = 1'b1;
                     cmd.st_at    = WR_INDEX;
                     cmd.st_value = ST_CLEAN;
                  end
                  cmd.idx_inc = 1'b1;
                  if (sts.idx_last) begin
                     state_in = S_FLUSH_END;
                  end
               end
            end else begin
               cmd.idx_inc = 1'b1;
               if (sts.idx_last) begin
                  state_in = S_FLUSH_END;
               end
            end
         end
         S_FLUSH_END: begin
            if (sts.out_free) begin
               cmd.emit    = 1'b1;
               cmd.kind    = sts.failed ? KIND_ERROR : KIND_DONE;
               cmd.buf_sel = BUF_ZERO;
               cmd.sec_sel = SEC_ZERO;
               cmd.last    = 1'b1;
               state_in    = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // A result is never loaded over one that is still waiting.
   `SBC_ASSERT_IMP(a_emit_when_free, clock, reset, cmd.emit, sts.out_free)
   // The final result of a request always returns the controller to idle.
   `SBC_ASSERT_NXT(a_last_goes_idle, clock, reset, cmd.emit && cmd.last, state_ff == S_IDLE)
   // An accepted request always starts work.
   `SBC_ASSERT_NXT(a_accept_starts, clock, reset, state_ff == S_IDLE && sts.req_valid,
                   state_ff == S_SCAN)

endmodule

// ===== rtl/core/sector_buffer_cache_lru_top.sv =====
// Channel      Direction  Contents
// req_port     in         op, sector, buffer_index, read_fails, write_fails
// rsp_port     out        kind, buffer, sector_out, last
//
// Load and allocate scan every buffer in turn for the tag, free and age scan, then issue
// up to three results before the next request is taken.
// Flush visits every buffer, writebacks included, then issues one final result; mark-dirty issues one result.
// A new request is taken only once the previous one has issued its last result.
// Reset frees all buffers and zeroes all ages; tags need no clearing.
// A stalled result register holds the controller in place; nothing is dropped.
//
// Top level of the sector buffer cache: controller and datapath.
// Depends on sbc_pkg, the channel interfaces, sbc_datapath and sbc_ctrl.
module sector_buffer_cache_lru_top import sbc_pkg::*; (
   input  logic      clock,
   input  logic      reset,
   sbc_req_if.sink   req_port,
   sbc_rsp_if.source rsp_port
);

   cmd_type cmd;
   sts_type sts;

   sbc_datapath u_datapath (
      .clock (clock),
      .reset (reset),
      .req   (req_port),
      .rsp   (rsp_port),
      .cmd   (cmd),
      .sts   (sts)
   );

   sbc_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .sts   (sts),
      .cmd   (cmd)
   );

endmodule
